[rtl/egr_pkg.sv]
// Shared types, codes and helpers for the ramped electronic gearing block.
package egr_pkg;

  localparam int NUM_SLAVES = 8;
  localparam int IDX_W = 3;
  localparam int CNT_W = 4;

  localparam logic [2:0] REQ_UPDATE     = 3'd0;
  localparam logic [2:0] REQ_ENGAGE     = 3'd1;
  localparam logic [2:0] REQ_DISENGAGE  = 3'd2;
  localparam logic [2:0] REQ_SET_RATIO  = 3'd3;
  localparam logic [2:0] REQ_SET_OFFSET = 3'd4;
  localparam logic [2:0] REQ_ADJ_OFFSET = 3'd5;
  localparam logic [2:0] REQ_SYNC       = 3'd6;
  localparam logic [2:0] REQ_UNKNOWN    = 3'd7;

  localparam logic [1:0] MODE_OFF      = 2'd0;
  localparam logic [1:0] MODE_ENGAGING = 2'd1;
  localparam logic [1:0] MODE_ENGAGED  = 2'd2;
  localparam logic [1:0] MODE_DISENG   = 2'd3;

  localparam logic [2:0] CFG_SLAVE_COUNT = 3'd0;
  localparam logic [2:0] CFG_RAMP_TIME   = 3'd1;
  localparam logic [2:0] CFG_SOFT_START  = 3'd2;
  localparam logic [2:0] CFG_FF_ENABLE   = 3'd3;
  localparam logic [2:0] CFG_FF_GAIN     = 3'd4;

  localparam logic [16:0] RAMP_ONE  = 17'h10000;
  localparam logic [19:0] US_PER_S  = 20'd1000000;
  localparam logic [9:0]  US_PER_MS = 10'd1000;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] sync;
    logic [31:0] engage;
    logic [31:0] start;
    logic [31:0] target;
    logic [15:0] num;
    logic [15:0] den;
    logic [31:0] offset;
  } follower_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [16:0] r;
  } ramp_t;

  localparam follower_t FOLLOWER_RESET = '{
    mode: MODE_OFF, sync: 32'd0, engage: 32'd0, start: 32'd0,
    target: 32'd0, num: 16'd0, den: 16'd1, offset: 32'd0
  };

  function automatic logic [31:0] abs32(logic [31:0] v);
    return v[31] ? 32'(32'd0 - v) : v;
  endfunction

  function automatic logic [15:0] abs16(logic [15:0] v);
    return v[15] ? 16'(16'd0 - v) : v;
  endfunction

  function automatic logic [31:0] sat32(logic signed [63:0] v);
    logic [31:0] res;
    if (v > 64'sd2147483647) res = 32'h7FFF_FFFF;
    else if (v < -64'sd2147483648) res = 32'h8000_0000;
    else res = v[31:0];
    return res;
  endfunction

  function automatic ramp_t ramp_apply(logic [1:0] mode, logic [16:0] rr);
    ramp_t res;
    res.mode = mode;
    res.r = (mode == MODE_DISENG) ? 17'(RAMP_ONE - rr) : rr;
    if (mode == MODE_ENGAGING && rr == RAMP_ONE) res.mode = MODE_ENGAGED;
    if (mode == MODE_DISENG && res.r == 17'd0) res.mode = MODE_OFF;
    return res;
  endfunction

endpackage

[rtl/electronic_gearing_ramped_core.sv]
// Ramped electronic gearing top level: request sequencer and datapath.
// Usage:
//   Input channel (in_valid_i / in_stall_o) takes one request: an update
//   tick or an operation on one follower. A request is taken only while the
//   sequencer is idle; in_stall_o is high for the whole time it works.
//   Output channel (out_valid_o / out_stall_i) gives one result for an
//   operation, or one result per follower in use for an update, with last_o
//   on the final one. Results go through a single output register, so a
//   new request is taken while the previous result still waits.
//   An operation reads the follower entry, applies the request and writes
//   it back with its result. An update first computes the master velocity
//   with a division when the time has advanced, then for each follower in
//   use runs up to three divisions in the shared radix-4 divider (ramp,
//   target and feed forward), plus multiply and memory-read steps.
//   Reset clears the configuration to defaults and marks every follower
//   entry as holding its reset value; no clearing pass is needed.
//   A stalled receiver freezes the sequencer at its next result.
//   Configuration writes must be made while the block is idle; the block itself does not enforce this.
module electronic_gearing_ramped_core import egr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [2:0]         req_type_i,
  input  logic [2:0]         slave_index_i,
  input  logic signed [31:0] master_position_i,
  input  logic signed [31:0] slave_actual_position_i,
  input  logic [31:0]        time_us_i,
  input  logic               soft_req_i,
  input  logic signed [15:0] numerator_i,
  input  logic signed [15:0] denominator_i,
  input  logic signed [31:0] offset_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         out_slave_o,
  output logic signed [31:0] target_position_o,
  output logic signed [31:0] ff_velocity_o,
  output logic               commanded_o,
  output logic               ff_valid_o,
  output logic [1:0]         slave_mode_out_o,
  output logic               ok_o,
  output logic               last_o
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_VMUL = 5'd1;
  localparam logic [4:0] S_VGO  = 5'd2;
  localparam logic [4:0] S_VDIV = 5'd3;
  localparam logic [4:0] S_RD   = 5'd4;
  localparam logic [4:0] S_EVAL = 5'd5;
  localparam logic [4:0] S_RDIV = 5'd6;
  localparam logic [4:0] S_CHK  = 5'd7;
  localparam logic [4:0] S_M1   = 5'd8;
  localparam logic [4:0] S_M2   = 5'd9;
  localparam logic [4:0] S_M3   = 5'd10;
  localparam logic [4:0] S_TGO  = 5'd11;
  localparam logic [4:0] S_F4   = 5'd12;
  localparam logic [4:0] S_FGO  = 5'd13;
  localparam logic [4:0] S_DIV  = 5'd14;
  localparam logic [4:0] S_EMIT = 5'd15;
  localparam logic [4:0] S_OPRD = 5'd16;
  localparam logic [4:0] S_OP   = 5'd17;

  // control state
  logic [4:0]       state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic [CNT_W-1:0] slave_count_q;
  logic [15:0]      ramp_time_q;
  logic             soft_start_q, ff_enable_q;
  logic [15:0]      ff_gain_q;
  logic [31:0]      prev_mpos_q, prev_mpos_d;
  logic [31:0]      prev_time_q, prev_time_d;
  logic [31:0]      vel_q, vel_d;

  // working registers
  logic [2:0]       req_q, req_d;
  logic [CNT_W-1:0] i_q, i_d;
  logic [31:0]      mpos_q, mpos_d, spos_q, spos_d, time_q, time_d, offv_q, offv_d;
  logic             soft_q, soft_d;
  logic [15:0]      num_q, num_d, den_q, den_d;
  logic [31:0]      dt_q, dt_d, dmag_q, dmag_d;
  logic             dneg_q, dneg_d;
  logic [51:0]      vprod_q, vprod_d;
  follower_t        ent_q, ent_d;
  logic [16:0]      r_q, r_d;
  logic             hit_q, hit_d, ok_q, ok_d, cmd_q, cmd_d, ffv_q, ffv_d;
  logic             ff_phase_q, ff_phase_d;
  logic [31:0]      ff_q, ff_d;
  logic [47:0]      p1_q, p1_d;
  logic [48:0]      plo_q, plo_d;
  logic [63:0]      acc_q, acc_d;
  logic [53:0]      th_q, th_d;
  logic [15:0]      tl_q, tl_d;

  // output register
  logic [2:0]       out_slave_q;
  logic [31:0]      out_target_q, out_ff_q;
  logic             out_cmd_q, out_ffv_q, out_ok_q, out_last_q;
  logic [1:0]       out_mode_q;

  // combinational
  logic             in_accept, out_free, out_load, req_hit, last_res;
  logic [CNT_W-1:0] cnt, i_next;
  logic [31:0]      mdiff, dm, el, xmag;
  logic [25:0]      ramp_us;
  logic [32:0]      mhi;
  logic [39:0]      glo;
  logic [55:0]      tsum;
  logic [16:0]      rr;
  ramp_t            rp;
  logic signed [63:0] sq, sv, tgt;
  logic             neg;
  follower_t        e;

  logic             div_start, div_done;
  logic [63:0]      div_dividend, div_quot;
  logic [31:0]      div_divisor;
  logic [4:0]       div_pairs;
  logic             mem_rd_en, mem_wr_en;
  follower_t        mem_rd_data;

  egr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .pairs_i    (div_pairs),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  egr_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (i_q[IDX_W-1:0]),
    .rd_data_o (mem_rd_data),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (i_q[IDX_W-1:0]),
    .wr_data_i (ent_q)
  );

  assign cnt = (slave_count_q > CNT_W'(NUM_SLAVES)) ? CNT_W'(NUM_SLAVES) : slave_count_q;
  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;
  assign i_next = CNT_W'(i_q + 1'b1);
  assign last_res = (req_q != REQ_UPDATE) || (i_next == cnt);
  assign req_hit = (CNT_W'(slave_index_i) < cnt);
  assign ramp_us = 26'(ramp_time_q) * 26'(US_PER_MS);

  always_comb begin
    state_d = state_q;
    out_valid_d = out_valid_q;
    prev_mpos_d = prev_mpos_q;
    prev_time_d = prev_time_q;
    vel_d = vel_q;
    req_d = req_q;
    i_d = i_q;
    mpos_d = mpos_q;
    spos_d = spos_q;
    time_d = time_q;
    offv_d = offv_q;
    soft_d = soft_q;
    num_d = num_q;
    den_d = den_q;
    dt_d = dt_q;
    dmag_d = dmag_q;
    dneg_d = dneg_q;
    vprod_d = vprod_q;
    ent_d = ent_q;
    r_d = r_q;
    hit_d = hit_q;
    ok_d = ok_q;
    cmd_d = cmd_q;
    ffv_d = ffv_q;
    ff_phase_d = ff_phase_q;
    ff_d = ff_q;
    p1_d = p1_q;
    plo_d = plo_q;
    acc_d = acc_q;
    th_d = th_q;
    tl_d = tl_q;
    out_load = 1'b0;
    mem_rd_en = 1'b0;
    mem_wr_en = 1'b0;
    div_start = 1'b0;
    div_dividend = '0;
    div_divisor = '0;
    div_pairs = '0;
    mdiff = 32'(master_position_i - prev_mpos_q);
    dm = 32'(mpos_q - ent_q.engage);
    el = 32'(time_q - mem_rd_data.start);
    xmag = ff_phase_q ? abs32(vel_q) : dmag_q;
    mhi = {17'd0, p1_q[47:32]} * {16'd0, r_q};
    glo = {16'd0, acc_q[23:0]} * {24'd0, ff_gain_q};
    tsum = {2'b0, th_q} + {40'd0, tl_q};
    rr = (div_quot > 64'(RAMP_ONE)) ? RAMP_ONE : div_quot[16:0];
    rp = ramp_apply(ent_q.mode, rr);
    sq = $signed(div_quot);
    neg = (ff_phase_q ? vel_q[31] : dneg_q) ^ ent_q.num[15] ^ ent_q.den[15];
    sv = neg ? -sq : sq;
    tgt = sv + $signed({{32{ent_q.sync[31]}}, ent_q.sync})
             + $signed({{32{ent_q.offset[31]}}, ent_q.offset});
    e = mem_rd_data;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          req_d = req_type_i;
          mpos_d = master_position_i;
          spos_d = slave_actual_position_i;
          time_d = time_us_i;
          soft_d = soft_req_i;
          num_d = numerator_i;
          den_d = denominator_i;
          offv_d = offset_value_i;
          cmd_d = 1'b0;
          ffv_d = 1'b0;
          ff_d = '0;
          if (req_type_i == REQ_UPDATE) begin
            hit_d = 1'b1;
            ok_d = 1'b1;
            i_d = '0;
            prev_mpos_d = master_position_i;
            prev_time_d = time_us_i;
            dt_d = 32'(time_us_i - prev_time_q);
            dmag_d = abs32(mdiff);
            dneg_d = mdiff[31];
            if (dt_d != 32'd0) state_d = S_VMUL;
            else if (cnt == '0) state_d = S_IDLE;
            else state_d = S_RD;
          end else begin
            i_d = CNT_W'(slave_index_i);
            hit_d = req_hit;
            ok_d = req_hit;
            state_d = req_hit ? S_OPRD : S_EMIT;
          end
        end
      end
      S_VMUL: begin
        vprod_d = {20'd0, dmag_q} * {32'd0, US_PER_S};
        state_d = S_VGO;
      end
      S_VGO: begin
        div_start = 1'b1;
        div_dividend = {vprod_q, 12'd0};
        div_divisor = dt_q;
        div_pairs = 5'd26;
        state_d = S_VDIV;
      end
      S_VDIV: begin
        if (div_done) begin
          vel_d = sat32(dneg_q ? -sq : sq);
          state_d = (cnt == '0) ? S_IDLE : S_RD;
        end
      end
      S_RD: begin
        mem_rd_en = 1'b1;
        cmd_d = 1'b0;
        ffv_d = 1'b0;
        ff_d = '0;
        ff_phase_d = 1'b0;
        state_d = S_EVAL;
      end
      S_EVAL: begin
        ent_d = mem_rd_data;
        if (mem_rd_data.mode == MODE_OFF) begin
          state_d = S_EMIT;
        end else if (mem_rd_data.mode == MODE_ENGAGED || ramp_time_q == 16'd0) begin
          rp = ramp_apply(mem_rd_data.mode, RAMP_ONE);
          r_d = rp.r;
          ent_d.mode = rp.mode;
          state_d = S_CHK;
        end else begin
          div_start = 1'b1;
          div_dividend = {el, 32'd0};
          div_divisor = {6'd0, ramp_us};
          div_pairs = 5'd24;
          state_d = S_RDIV;
        end
      end
      S_RDIV: begin
        if (div_done) begin
          r_d = rp.r;
          ent_d.mode = rp.mode;
          state_d = S_CHK;
        end
      end
      S_CHK: begin
        if (ent_q.mode == MODE_OFF) begin
          state_d = S_EMIT;
        end else begin
          dmag_d = abs32(dm);
          dneg_d = dm[31];
          cmd_d = 1'b1;
          state_d = S_M1;
        end
      end
      S_M1: begin
        p1_d = {16'd0, xmag} * {32'd0, abs16(ent_q.num)};
        state_d = S_M2;
      end
      S_M2: begin
        plo_d = {17'd0, p1_q[31:0]} * {32'd0, r_q};
        state_d = S_M3;
      end
      S_M3: begin
        acc_d = {15'd0, plo_q} + {mhi[31:0], 32'd0};
        state_d = ff_phase_q ? S_F4 : S_TGO;
      end
      S_TGO: begin
        div_start = 1'b1;
        div_dividend = {acc_q[63:16], 16'd0};
        div_divisor = {16'd0, abs16(ent_q.den)};
        div_pairs = 5'd24;
        state_d = S_DIV;
      end
      S_F4: begin
        th_d = {15'd0, acc_q[62:24]} * {38'd0, ff_gain_q};
        tl_d = glo[39:24];
        state_d = S_FGO;
      end
      S_FGO: begin
        div_start = 1'b1;
        div_dividend = {tsum, 8'd0};
        div_divisor = {16'd0, abs16(ent_q.den)};
        div_pairs = 5'd28;
        state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (!ff_phase_q) begin
            ent_d.target = sat32(tgt);
            if (ff_enable_q) begin
              ff_phase_d = 1'b1;
              ffv_d = 1'b1;
              state_d = S_M1;
            end else begin
              state_d = S_EMIT;
            end
          end else begin
            ff_d = sat32(sv);
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          mem_wr_en = hit_q;
          if (req_q == REQ_UPDATE && i_next != cnt) begin
            i_d = i_next;
            state_d = S_RD;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_OPRD: begin
        mem_rd_en = 1'b1;
        state_d = S_OP;
      end
      S_OP: begin
        case (req_q)
          REQ_ENGAGE: begin
            if (e.mode != MODE_ENGAGED) begin
              e.sync = spos_q;
              e.engage = mpos_q;
              e.start = time_q;
              e.mode = (soft_q && soft_start_q && ramp_time_q != 16'd0) ?
                       MODE_ENGAGING : MODE_ENGAGED;
            end
          end
          REQ_DISENGAGE: begin
            if (e.mode != MODE_OFF) begin
              if (soft_q && ramp_time_q != 16'd0) begin
                e.mode = MODE_DISENG;
                e.start = time_q;
              end else begin
                e.mode = MODE_OFF;
              end
            end
          end
          REQ_SET_RATIO: begin
            if (den_q == 16'd0) begin
              ok_d = 1'b0;
            end else begin
              e.num = num_q;
              e.den = den_q;
            end
          end
          REQ_SET_OFFSET: e.offset = offv_q;
          REQ_ADJ_OFFSET: e.offset = 32'(e.offset + offv_q);
          REQ_SYNC: begin
            e.sync = spos_q;
            e.engage = mpos_q;
          end
          default: ok_d = 1'b0;
        endcase
        ent_d = e;
        state_d = S_EMIT;
      end
      default: state_d = S_IDLE;
    endcase

    if (out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      out_valid_q <= 1'b0;
      prev_mpos_q <= '0;
      prev_time_q <= '0;
      vel_q <= '0;
      slave_count_q <= '0;
      ramp_time_q <= '0;
      soft_start_q <= 1'b1;
      ff_enable_q <= 1'b0;
      ff_gain_q <= 16'd256;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
      prev_mpos_q <= prev_mpos_d;
      prev_time_q <= prev_time_d;
      vel_q <= vel_d;
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_SLAVE_COUNT: slave_count_q <= cfg_data_i[CNT_W-1:0];
          CFG_RAMP_TIME:   ramp_time_q <= cfg_data_i;
          CFG_SOFT_START:  soft_start_q <= cfg_data_i[0];
          CFG_FF_ENABLE:   ff_enable_q <= cfg_data_i[0];
          CFG_FF_GAIN:     ff_gain_q <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q <= req_d;
    i_q <= i_d;
    mpos_q <= mpos_d;
    spos_q <= spos_d;
    time_q <= time_d;
    offv_q <= offv_d;
    soft_q <= soft_d;
    num_q <= num_d;
    den_q <= den_d;
    dt_q <= dt_d;
    dmag_q <= dmag_d;
    dneg_q <= dneg_d;
    vprod_q <= vprod_d;
    ent_q <= ent_d;
    r_q <= r_d;
    hit_q <= hit_d;
    ok_q <= ok_d;
    cmd_q <= cmd_d;
    ffv_q <= ffv_d;
    ff_phase_q <= ff_phase_d;
    ff_q <= ff_d;
    p1_q <= p1_d;
    plo_q <= plo_d;
    acc_q <= acc_d;
    th_q <= th_d;
    tl_q <= tl_d;
    if (out_load) begin
      out_slave_q <= i_q[IDX_W-1:0];
      out_target_q <= hit_q ? ent_q.target : 32'd0;
      out_ff_q <= ff_q;
      out_cmd_q <= cmd_q;
      out_ffv_q <= ffv_q;
      out_mode_q <= hit_q ? ent_q.mode : MODE_OFF;
      out_ok_q <= ok_q;
      out_last_q <= last_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_slave_o = out_slave_q;
  assign target_position_o = out_target_q;
  assign ff_velocity_o = out_ff_q;
  assign commanded_o = out_cmd_q;
  assign ff_valid_o = out_ffv_q;
  assign slave_mode_out_o = out_mode_q;
  assign ok_o = out_ok_q;
  assign last_o = out_last_q;

`ifndef ASSERT_OFF
  a_ffv_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && ff_valid_o |-> commanded_o) else $error("ff without command");
  a_cmd_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && commanded_o |-> (slave_mode_out_o != MODE_OFF) && ok_o)
    else $error("command for disengaged follower");
  a_div_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == S_VDIV || state_q == S_RDIV || state_q == S_DIV))
    else $error("division finished outside a wait state");
`endif

endmodule

[rtl/egr_div.sv]
// Radix-4 restoring divider, two quotient bits per cycle.
module egr_div import egr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] dividend_i,
  input  logic [31:0] divisor_i,
  input  logic [4:0]  pairs_i,
  output logic        done_o,
  output logic [63:0] quotient_o
);

  logic [63:0] dvd_q, dvd_d;
  logic [31:0] rem_q, rem_d;
  logic [31:0] dsr_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q;
  logic [32:0] shl;

  always_comb begin
    rem_d = rem_q;
    dvd_d = dvd_q;
    shl = '0;
    for (int k = 0; k < 2; k++) begin
      shl = {rem_d, dvd_d[63]};
      dvd_d = {dvd_d[62:0], 1'b0};
      if (shl >= {1'b0, dsr_q}) begin
        rem_d = 32'(shl - {1'b0, dsr_q});
        dvd_d[0] = 1'b1;
      end else begin
        rem_d = shl[31:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= pairs_i;
    end else if (busy_q) begin
      cnt_q <= 5'(cnt_q - 5'd1);
      if (cnt_q == 5'd1) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign quotient_o = dvd_q;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !busy_q) else $error("divider started while busy");
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q) else $error("divider done while busy");
`endif

endmodule

[rtl/egr_mem.sv]
// Follower state memory with registered read and per-entry reset valid bits.
module egr_mem import egr_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [IDX_W-1:0] rd_addr_i,
  output follower_t        rd_data_o,
  input  logic             wr_en_i,
  input  logic [IDX_W-1:0] wr_addr_i,
  input  follower_t        wr_data_i
);

  follower_t             mem_q [NUM_SLAVES];
  logic [NUM_SLAVES-1:0] valid_q;
  follower_t             rd_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) mem_q[wr_addr_i] <= wr_data_i;
    if (rd_en_i) rd_data_q <= valid_q[rd_addr_i] ? mem_q[rd_addr_i] : FOLLOWER_RESET;
  end

  assign rd_data_o = rd_data_q;

endmodule

[tb/sv/tb_top.sv]
// Testbench for the ramped electronic gearing core: directed and random requests with a predictor.
`timescale 1ns / 1ps
module tb_top;
  import egr_pkg::*;

  typedef struct {
    logic [2:0]  slv;
    logic [31:0] tgt;
    logic [31:0] ffv;
    logic        cmd;
    logic        ffok;
    logic [1:0]  mode;
    logic        ok;
    logic        last;
  } gear_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [15:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [2:0] req_type_i = '0;
  logic [2:0] slave_index_i = '0;
  logic signed [31:0] master_position_i = '0;
  logic signed [31:0] slave_actual_position_i = '0;
  logic [31:0] time_us_i = '0;
  logic soft_req_i = 1'b0;
  logic signed [15:0] numerator_i = '0;
  logic signed [15:0] denominator_i = '0;
  logic signed [31:0] offset_value_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [2:0] out_slave_o;
  logic signed [31:0] target_position_o;
  logic signed [31:0] ff_velocity_o;
  logic commanded_o, ff_valid_o, ok_o, last_o;
  logic [1:0] slave_mode_out_o;

  electronic_gearing_ramped_core uut (.*);

  always #2 clk_i = ~clk_i;

  // predictor state
  logic [1:0]  f_mode [NUM_SLAVES];
  logic [31:0] f_sync [NUM_SLAVES];
  logic [31:0] f_eng [NUM_SLAVES];
  logic [31:0] f_start [NUM_SLAVES];
  logic [31:0] f_tgt [NUM_SLAVES];
  logic signed [15:0] f_num [NUM_SLAVES];
  logic signed [15:0] f_den [NUM_SLAVES];
  logic [31:0] f_off [NUM_SLAVES];
  logic [31:0] prev_pos, prev_time;
  logic signed [31:0] mvel;
  logic [3:0] c_count;
  logic [15:0] c_ramp, c_gain;
  logic c_soft, c_ffen;

  gear_res_t pending[$];
  int errors = 0;
  int n_items = 0;
  int n_results = 0;
  bit quiet = 0;

  function automatic logic [31:0] clamp32(longint v);
    if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint ramp_of(int i, logic [31:0] now);
    longint unsigned el, r;
    if (f_mode[i] == MODE_ENGAGED) return 65536;
    if (f_mode[i] == MODE_OFF) return 0;
    if (c_ramp == 0) r = 65536;
    else begin
      el = 64'(32'(now - f_start[i]));
      r = (el << 16) / (64'(c_ramp) * 1000);
      if (r > 65536) r = 65536;
    end
    return f_mode[i] == MODE_ENGAGING ? longint'(r) : 65536 - longint'(r);
  endfunction

  function automatic logic [31:0] ff_of(int i, longint r);
    longint num, den, vel;
    longint unsigned m, t, q;
    bit neg;
    num = f_num[i];
    den = f_den[i];
    vel = mvel;
    if (den == 0) return 0;
    neg = ((vel < 0) != (num < 0)) != (den < 0);
    m = longint'(vel < 0 ? -vel : vel) * longint'(num < 0 ? -num : num) * r;
    t = (m >> 24) * c_gain + (((m & 64'hFFFFFF) * c_gain) >> 24);
    q = t / longint'(den < 0 ? -den : den);
    if (q > 64'h8000_0000) q = 64'h8000_0000;
    return clamp32(neg ? -longint'(q) : longint'(q));
  endfunction

  task automatic predict_gearing(logic [2:0] rq, logic [2:0] idx, logic [31:0] mpos,
                                 logic [31:0] spos, logic [31:0] now, logic soft_rq,
                                 logic signed [15:0] num, logic signed [15:0] den,
                                 logic [31:0] offv);
    int cnt;
    logic [31:0] dt;
    longint d, r, dm, q, t;
    gear_res_t e;
    logic ok;
    cnt = c_count > NUM_SLAVES ? NUM_SLAVES : c_count;
    if (rq == REQ_UPDATE) begin
      dt = now - prev_time;
      if (dt != 0) begin
        d = longint'($signed(32'(mpos - prev_pos)));
        mvel = clamp32(d * 1000000 / longint'(dt));
      end
      prev_pos = mpos;
      prev_time = now;
      for (int i = 0; i < cnt; i++) begin
        e = '{slv: 3'(i), tgt: 0, ffv: 0, cmd: 0, ffok: 0, mode: 0, ok: 1,
              last: (i + 1 == cnt)};
        if (f_mode[i] != MODE_OFF) begin
          r = ramp_of(i, now);
          if (f_mode[i] == MODE_ENGAGING && r >= 65536) f_mode[i] = MODE_ENGAGED;
          else if (f_mode[i] == MODE_DISENG && r <= 0) f_mode[i] = MODE_OFF;
          if (f_mode[i] != MODE_OFF && f_den[i] != 0) begin
            dm = longint'($signed(32'(mpos - f_eng[i])));
            q = dm * longint'(f_num[i]) * r / (longint'(f_den[i]) * 65536);
            t = longint'($signed(f_sync[i])) + q + longint'($signed(f_off[i]));
            f_tgt[i] = clamp32(t);
            e.cmd = 1;
            if (c_ffen) begin
              e.ffv = ff_of(i, r);
              e.ffok = 1;
            end
          end
        end
        e.tgt = f_tgt[i];
        e.mode = f_mode[i];
        pending.insert(pending.size(), e);
      end
      return;
    end
    ok = 1;
    if (idx >= cnt || rq == REQ_UNKNOWN) ok = 0;
    else case (rq)
      REQ_ENGAGE: begin
        if (f_mode[idx] != MODE_ENGAGED) begin
          f_sync[idx] = spos;
          f_eng[idx] = mpos;
          f_start[idx] = now;
          f_mode[idx] = (soft_rq && c_soft && c_ramp > 0) ? MODE_ENGAGING : MODE_ENGAGED;
        end
      end
      REQ_DISENGAGE: begin
        if (f_mode[idx] != MODE_OFF) begin
          if (soft_rq && c_ramp > 0) begin
            f_mode[idx] = MODE_DISENG;
            f_start[idx] = now;
          end else f_mode[idx] = MODE_OFF;
        end
      end
      REQ_SET_RATIO: begin
        if (den == 0) ok = 0;
        else begin
          f_num[idx] = num;
          f_den[idx] = den;
        end
      end
      REQ_SET_OFFSET: f_off[idx] = offv;
      REQ_ADJ_OFFSET: f_off[idx] = f_off[idx] + offv;
      default: begin
        f_sync[idx] = spos;
        f_eng[idx] = mpos;
      end
    endcase
    e = '{slv: idx, tgt: 0, ffv: 0, cmd: 0, ffok: 0, mode: 0, ok: ok, last: 1};
    if (idx < cnt) begin
      e.tgt = f_tgt[idx];
      e.mode = f_mode[idx];
    end
    pending.insert(pending.size(), e);
  endtask

  // random receiver stall
  always @(negedge clk_i) begin
    if (quiet) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < 20);
  end

  always @(posedge clk_i) begin
    gear_res_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      n_results++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result slave %0d tgt %0d", $time, out_slave_o,
                 target_position_o);
        errors++;
      end else begin
        e = pending.pop_front();
        if (out_slave_o !== e.slv || target_position_o !== e.tgt ||
            ff_velocity_o !== e.ffv || commanded_o !== e.cmd || ff_valid_o !== e.ffok ||
            slave_mode_out_o !== e.mode || ok_o !== e.ok || last_o !== e.last) begin
          $display("%0t: mismatch exp slv=%0d tgt=%h ff=%h cmd=%b ffv=%b mode=%0d ok=%b last=%b",
                   $time, e.slv, e.tgt, e.ffv, e.cmd, e.ffok, e.mode, e.ok, e.last);
          $display("%0t:          act slv=%0d tgt=%h ff=%h cmd=%b ffv=%b mode=%0d ok=%b last=%b",
                   $time, out_slave_o, target_position_o, ff_velocity_o, commanded_o,
                   ff_valid_o, slave_mode_out_o, ok_o, last_o);
          errors++;
        end
      end
    end
  end

  task automatic send_request(logic [2:0] rq, logic [2:0] idx, logic [31:0] mpos,
                              logic [31:0] spos, logic [31:0] now, logic soft_rq,
                              logic [15:0] num, logic [15:0] den, logic [31:0] offv);
    @(negedge clk_i);
    while (!quiet && $urandom_range(99) < 20) @(negedge clk_i);
    req_type_i <= rq;
    slave_index_i <= idx;
    master_position_i <= mpos;
    slave_actual_position_i <= spos;
    time_us_i <= now;
    soft_req_i <= soft_rq;
    numerator_i <= num;
    denominator_i <= den;
    offset_value_i <= offv;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_gearing(rq, idx, mpos, spos, now, soft_rq, num, den, offv);
    n_items++;
    @(negedge clk_i);
    in_valid_i <= 1'b0;
  endtask

  task automatic drain;
    while (pending.size() != 0) @(negedge clk_i);
    repeat (900) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_SLAVE_COUNT: c_count = val[3:0];
      CFG_RAMP_TIME:   c_ramp = val;
      CFG_SOFT_START:  c_soft = val[0];
      CFG_FF_ENABLE:   c_ffen = val[0];
      default:         c_gain = val;
    endcase
  endtask

  logic [31:0] clk_us = 0;

  task automatic test_defaults;
    send_request(REQ_UPDATE, 0, 32'd100, 0, 32'd10, 0, 0, 0, 0);
    send_request(REQ_ENGAGE, 0, 0, 0, 32'd20, 0, 0, 0, 0);
    send_request(REQ_UNKNOWN, 0, 0, 0, 0, 0, 0, 0, 0);
    drain();
  endtask

  task automatic test_directed;
    write_reg(CFG_SLAVE_COUNT, 16'd15);
    write_reg(CFG_RAMP_TIME, 16'd1);
    write_reg(CFG_SOFT_START, 16'd1);
    write_reg(CFG_FF_ENABLE, 16'd1);
    write_reg(CFG_FF_GAIN, 16'hFFFF);
    send_request(REQ_SET_RATIO, 0, 0, 0, 0, 0, 16'h7FFF, 16'h0000, 0);
    send_request(REQ_SET_RATIO, 0, 0, 0, 0, 0, 16'h8000, 16'h8000, 0);
    send_request(REQ_SET_RATIO, 1, 0, 0, 0, 0, 16'h7FFF, 16'h0001, 0);
    send_request(REQ_SET_OFFSET, 1, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF);
    send_request(REQ_ADJ_OFFSET, 1, 0, 0, 0, 0, 0, 0, 32'h7FFF_FFFF);
    send_request(REQ_ENGAGE, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'd100, 1, 0, 0, 0);
    send_request(REQ_ENGAGE, 1, 32'h0, 32'h8000_0000, 32'd100, 0, 0, 0, 0);
    send_request(REQ_ENGAGE, 1, 32'h5, 32'h5, 32'd100, 0, 0, 0, 0);
    send_request(REQ_UPDATE, 0, 32'h7FFF_FFFF, 0, 32'd101, 0, 0, 0, 0);
    send_request(REQ_UPDATE, 0, 32'h8000_0000, 0, 32'd101, 0, 0, 0, 0);
    send_request(REQ_UPDATE, 0, 32'h8000_0000, 0, 32'd600, 0, 0, 0, 0);
    send_request(REQ_UPDATE, 0, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 0, 0, 0, 0);
    send_request(REQ_DISENGAGE, 0, 0, 0, 32'hFFFF_FFFF, 1, 0, 0, 0);
    send_request(REQ_UPDATE, 0, 0, 0, 32'd200, 0, 0, 0, 0);
    send_request(REQ_SYNC, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0, 0, 0, 0);
    send_request(REQ_DISENGAGE, 1, 0, 0, 0, 0, 0, 0, 0);
    send_request(REQ_DISENGAGE, 1, 0, 0, 0, 1, 0, 0, 0);
    send_request(REQ_UPDATE, 7, 32'd50, 0, 32'd5000, 0, 0, 0, 0);
    drain();
    write_reg(CFG_SLAVE_COUNT, 16'd2);
    send_request(REQ_SET_OFFSET, 7, 0, 0, 0, 0, 0, 0, 32'd1);
    send_request(REQ_ENGAGE, 0, 0, 0, 32'd6000, 1, 0, 0, 0);
    drain();
    write_reg(CFG_RAMP_TIME, 16'd0);
    send_request(REQ_UPDATE, 0, 32'd9, 0, 32'd6001, 0, 0, 0, 0);
    drain();
    write_reg(CFG_SLAVE_COUNT, 16'd0);
    send_request(REQ_UPDATE, 0, 32'd9, 0, 32'd6002, 0, 0, 0, 0);
    drain();
    clk_us = 32'd7000;
  endtask

  task automatic random_phase(int n, bit calm);
    logic [2:0] rq;
    logic [31:0] mp;
    quiet = calm;
    for (int k = 0; k < n; k++) begin
      rq = ($urandom_range(99) < 35) ? REQ_UPDATE : 3'($urandom_range(7));
      clk_us += ($urandom_range(9) == 0) ? $urandom : $urandom_range(3000);
      mp = ($urandom_range(3) == 0) ? $urandom : 32'($signed(32'(clk_us)) >>> 2);
      send_request(rq, 3'($urandom), mp, $urandom, clk_us, 1'($urandom),
                   ($urandom_range(7) == 0) ? 16'h0 : 16'($urandom),
                   ($urandom_range(7) == 0) ? 16'h0 : 16'($urandom_range(40) - 20),
                   $urandom);
      if (k == n / 2) begin
        while (pending.size() != 0) @(negedge clk_i);
      end
    end
    drain();
  endtask

  task automatic test_random;
    write_reg(CFG_SLAVE_COUNT, 16'd8);
    write_reg(CFG_RAMP_TIME, 16'd3);
    write_reg(CFG_FF_GAIN, 16'd256);
    random_phase(28, 0);
    write_reg(CFG_SLAVE_COUNT, 16'd3);
    write_reg(CFG_RAMP_TIME, 16'hFFFF);
    write_reg(CFG_SOFT_START, 16'd0);
    write_reg(CFG_FF_GAIN, 16'd0);
    random_phase(22, 1);
    write_reg(CFG_SLAVE_COUNT, 16'd5);
    write_reg(CFG_RAMP_TIME, 16'd2);
    write_reg(CFG_SOFT_START, 16'd1);
    write_reg(CFG_FF_ENABLE, 16'd0);
    write_reg(CFG_FF_GAIN, 16'h1234);
    random_phase(26, 0);
  endtask

  initial begin
    for (int i = 0; i < NUM_SLAVES; i++) begin
      f_mode[i] = MODE_OFF; f_sync[i] = 0; f_eng[i] = 0; f_start[i] = 0;
      f_tgt[i] = 0; f_num[i] = 0; f_den[i] = 1; f_off[i] = 0;
    end
    prev_pos = 0; prev_time = 0; mvel = 0;
    c_count = 0; c_ramp = 0; c_soft = 1; c_ffen = 0; c_gain = 256;
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_defaults();
    test_directed();
    test_random();
    $display("Sent %0d requests, checked %0d results over several register settings.",
             n_items, n_results);
    if (errors == 0 && pending.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("Timeout");
    $display("Some tests failed");
    $finish;
  end
endmodule

[sim.f]
rtl/egr_pkg.sv
rtl/egr_div.sv
rtl/egr_mem.sv
rtl/electronic_gearing_ramped_core.sv
tb/sv/tb_top.sv
